### hdl/ria_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ria_pkg
// Shared types and constants of the reference counted index allocator:
// request and response payloads, cell token and broadcast command structs.
// ----------------------------------------------------------------------------
package ria_pkg;

    // table geometry
    localparam int ENTRIES  = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int LVL_W    = $clog2(ENTRIES + 1);
    localparam int KEY_W    = 32;
    localparam int KEY_BITS = 32;   // low key bits that take part in the compare, 8..32
    localparam int CNT_W    = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // request actions
    localparam logic ACT_ASSIGN  = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // response status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] slot_index;
        logic [CNT_W-1:0] ref_count;
        logic             was_present;
        logic             released;
        logic [1:0]       status;
    } rsp_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic             active;
        logic             found;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } tok_t;

    // table entry write broadcast to all cells
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    pos;
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    count;
    } tbl_wr_t;

    // free stack shift command
    typedef struct packed {
        logic push;
        logic pop;
    } stk_op_t;

endpackage

### hdl/refcounted_index_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_index_allocator
// Maps keys to dense slot indices with reference counts and a free stack.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_req carry one request: action (assign or release) and
//   key. m_valid/m_ready/m_rsp carry one response per request: slot index,
//   count after the request, was_present, released and status.
//   The key table is a row of ENTRIES cells; a search token walks the row
//   one cell per cycle. No new request is taken until the response of
//   the one in flight has been committed to the output register.
//   The free stack is a second row of cells that shifts on push and pop.
//   s_ready is high whenever no request is in flight, even while the
//   previous response still waits. If m_ready is low when a search ends,
//   the block holds the result and commits nothing until the output
//   register frees up, so no response is lost.
//   Reset (aresetn low, synchronous) empties the table, the free stack and
//   the live count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module refcounted_index_allocator
    import ria_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_SEARCH,
        S_COMMIT
    } state_t;

    state_t           state_reg;
    req_t             req_reg;
    tok_t             hit_reg;
    rsp_t             rsp_reg;
    logic             m_valid_reg;
    logic [LVL_W-1:0] live_reg;
    logic [LVL_W-1:0] live_next;
    logic [LVL_W-1:0] depth_reg;
    logic [LVL_W-1:0] depth_next;

    tok_t             tok_chain [ENTRIES+1];
    logic [IDX_W-1:0] stk_val   [ENTRIES];

    rsp_t             dec_rsp;
    tbl_wr_t          dec_wr;
    stk_op_t          dec_stk;
    tbl_wr_t          tbl_wr;
    stk_op_t          stk_op;
    logic [IDX_W-1:0] push_val;
    logic [IDX_W-1:0] new_idx;
    logic [CNT_W-1:0] rel_cnt;
    logic             s_fire;
    logic             commit;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign commit  = (state_reg == S_COMMIT) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    // token enters the first cell in the cycle after the request is taken
    always_comb begin
        tok_chain[0]        = '0;
        tok_chain[0].active = (state_reg == S_LAUNCH);
    end

    // key table cell row
    for (genvar i = 0; i < ENTRIES; i++) begin : g_table
        ria_table_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_idx   (IDX_W'(i)),
            .search_key (req_reg.key[KEY_BITS-1:0]),
            .wr         (tbl_wr),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1])
        );
    end

    // free stack cell row, top at position zero
    for (genvar i = 0; i < ENTRIES; i++) begin : g_stack
        logic [IDX_W-1:0] prev_v;
        logic [IDX_W-1:0] next_v;
        if (i == 0) begin : g_top
            assign prev_v = push_val;
        end else begin : g_mid
            assign prev_v = stk_val[i-1];
        end
        if (i == ENTRIES - 1) begin : g_bot
            assign next_v = '0;
        end else begin : g_up
            assign next_v = stk_val[i+1];
        end
        ria_stack_cell u_cell (
            .aclk     (aclk),
            .op       (stk_op),
            .prev_val (prev_v),
            .next_val (next_v),
            .val      (stk_val[i])
        );
    end

    assign rel_cnt  = (hit_reg.count != '0) ? hit_reg.count - 1'b1 : '0;
    assign new_idx  = (depth_reg != '0) ? stk_val[0] : live_reg[IDX_W-1:0];
    assign push_val = hit_reg.pos;

    // outcome of the request from the search result
    always_comb begin
        dec_rsp    = '0;
        dec_wr     = '0;
        dec_stk    = '0;
        live_next  = live_reg;
        depth_next = depth_reg;
        dec_wr.key = req_reg.key[KEY_BITS-1:0];
        if (req_reg.action == ACT_ASSIGN) begin
            if (hit_reg.found) begin
                dec_rsp.slot_index  = hit_reg.pos;
                dec_rsp.was_present = 1'b1;
                if (hit_reg.count == COUNT_MAX) begin
                    dec_rsp.ref_count = COUNT_MAX;
                    dec_rsp.status    = ST_SATURATED;
                end else begin
                    dec_rsp.ref_count = hit_reg.count + 1'b1;
                    dec_rsp.status    = ST_OK;
                    dec_wr.en         = 1'b1;
                    dec_wr.pos        = hit_reg.pos;
                    dec_wr.valid      = 1'b1;
                    dec_wr.count      = hit_reg.count + 1'b1;
                end
            end else if (live_reg >= LVL_W'(ENTRIES)) begin
                dec_rsp.status = ST_FULL;
            end else begin
                // new key: recycled index first, else the next dense one
                if (depth_reg != '0) begin
                    dec_stk.pop = 1'b1;
                    depth_next  = depth_reg - 1'b1;
                end
                live_next         = live_reg + 1'b1;
                dec_wr.en         = 1'b1;
                dec_wr.pos        = new_idx;
                dec_wr.valid      = 1'b1;
                dec_wr.count      = CNT_W'(1);
                dec_rsp.slot_index = new_idx;
                dec_rsp.ref_count = CNT_W'(1);
                dec_rsp.status    = ST_OK;
            end
        end else begin
            if (!hit_reg.found) begin
                dec_rsp.status = ST_NOT_FOUND;
            end else begin
                dec_rsp.slot_index  = hit_reg.pos;
                dec_rsp.ref_count   = rel_cnt;
                dec_rsp.was_present = 1'b1;
                dec_rsp.status      = ST_OK;
                dec_wr.en           = 1'b1;
                dec_wr.pos          = hit_reg.pos;
                dec_wr.count        = rel_cnt;
                dec_wr.valid        = (rel_cnt != '0);
                if (rel_cnt == '0) begin
                    // last reference gone: index back to the free stack
                    dec_rsp.released = 1'b1;
                    if (depth_reg < LVL_W'(ENTRIES)) begin
                        dec_stk.push = 1'b1;
                        depth_next   = depth_reg + 1'b1;
                    end
                    if (live_reg != '0) begin
                        live_next = live_reg - 1'b1;
                    end
                end
            end
        end
    end

    // state changes only when the response is committed
    always_comb begin
        tbl_wr      = dec_wr;
        tbl_wr.en   = dec_wr.en && commit;
        stk_op.push = dec_stk.push && commit;
        stk_op.pop  = dec_stk.pop && commit;
    end

    // request sequencer, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            live_reg    <= '0;
            depth_reg   <= '0;
            hit_reg     <= '0;
        end else begin
            // a commit in the same cycle reloads the output register instead
            if (m_valid_reg && m_ready && !commit) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        req_reg   <= s_req;
                        state_reg <= S_LAUNCH;
                    end
                end
                S_LAUNCH: begin
                    state_reg <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (tok_chain[ENTRIES].active) begin
                        hit_reg   <= tok_chain[ENTRIES];
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (commit) begin
                        rsp_reg     <= dec_rsp;
                        m_valid_reg <= 1'b1;
                        live_reg    <= live_next;
                        depth_reg   <= depth_next;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // live and free counts together never exceed the table size
    a_level_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, live_reg} + {1'b0, depth_reg}) <= (LVL_W + 1)'(ENTRIES))
        else $error("live plus free count exceeds table size");

    // the token leaves the row only during a search
    a_token_state: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_chain[ENTRIES].active |-> (state_reg == S_SEARCH))
        else $error("search token out of sequence");

    // a response appears only after a commit
    a_rsp_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_COMMIT))
        else $error("response without commit");

    // a committed new key raises the live count by one
    a_new_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (req_reg.action == ACT_ASSIGN) && !hit_reg.found
            && (dec_rsp.status == ST_OK))
        |=> (live_reg == $past(live_reg) + 1'b1))
        else $error("live count not advanced on new key");

    // table and stack never change outside a commit
    a_quiet_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |-> (!tbl_wr.en && !stk_op.push && !stk_op.pop))
        else $error("state update outside commit");
`endif

endmodule

### hdl/ria_table_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ria_table_cell
// One table entry: valid flag, key and reference count. Compares the
// broadcast key as the search token passes and hands the token on.
// ----------------------------------------------------------------------------
module ria_table_cell
    import ria_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [IDX_W-1:0]    cell_idx,
    input  logic [KEY_BITS-1:0] search_key,
    input  tbl_wr_t             wr,
    input  tok_t                tok_in,
    output tok_t                tok_out
);

    logic                valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CNT_W-1:0]    count_reg;
    tok_t                tok_reg;
    tok_t                tok_next;
    logic                wr_hit;

    assign wr_hit = wr.en && (wr.pos == cell_idx);

    // entry valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_hit) begin
            valid_reg <= wr.valid;
        end
    end

    // entry key and count
    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            key_reg   <= wr.key;
            count_reg <= wr.count;
        end
    end

    // match this entry as the token passes
    always_comb begin
        tok_next = tok_in;
        if (tok_in.active && valid_reg && (key_reg == search_key)) begin
            tok_next.found = 1'b1;
            tok_next.pos   = cell_idx;
            tok_next.count = count_reg;
        end
    end

    // token stage toward the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### hdl/ria_stack_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ria_stack_cell
// One free stack element. A push takes the value of the cell above, a pop
// takes the value of the cell below; the top cell faces the push data.
// ----------------------------------------------------------------------------
module ria_stack_cell
    import ria_pkg::*;
(
    input  logic             aclk,
    input  stk_op_t          op,
    input  logic [IDX_W-1:0] prev_val,
    input  logic [IDX_W-1:0] next_val,
    output logic [IDX_W-1:0] val
);

    logic [IDX_W-1:0] val_reg;

    // shift toward the bottom on push, toward the top on pop
    always_ff @(posedge aclk) begin
        if (op.push) begin
            val_reg <= prev_val;
        end else if (op.pop) begin
            val_reg <= next_val;
        end
    end

    assign val = val_reg;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for refcounted_index_allocator. Every accepted request
// goes through a local copy of the key table and free stack. The predicted
// response is queued and then compared field by field with the block's
// response. The tests cover basic assign and release, a long count walk,
// a full table, output back-pressure and a long random traffic mix. The
// sender idles in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
    import ria_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_REQUESTS = 1150;
    localparam int REPORT_LINES    = 40;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req   = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;

    // local copy of the allocator state
    logic                tbl_valid  [ENTRIES];
    logic [KEY_BITS-1:0] tbl_key    [ENTRIES];
    logic [CNT_W-1:0]    tbl_count  [ENTRIES];
    logic [IDX_W-1:0]    free_stack [ENTRIES];
    logic [LVL_W-1:0]    free_depth = '0;
    logic [LVL_W-1:0]    live_cnt   = '0;

    rsp_t alloc_rsp_due [$];

    // pacing controls
    bit tx_steady  = 1'b0;
    bit rx_steady  = 1'b0;
    int burst_left = 0;
    int hold_ask   = 0;
    int hold_left  = 0;
    int stall_left = 0;

    int mismatches  = 0;
    int idle_cycles = 0;
    int n_ok        = 0;
    int n_not_found = 0;
    int n_full      = 0;
    int n_saturated = 0;

    refcounted_index_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    // clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
        end
    end

    // associative lookup on the low key bits
    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_key[i] == key[KEY_BITS-1:0]) return i;
        end
        return -1;
    endfunction

    // apply one request to the local table, return the response it must give
    function automatic rsp_t apply_alloc_request(input req_t r);
        rsp_t             o;
        int               pos;
        logic [IDX_W-1:0] hit;
        logic [IDX_W-1:0] idx;
        o = '0;
        pos = find_slot(r.key);
        hit = pos[IDX_W-1:0];
        if (r.action == ACT_ASSIGN) begin
            if (pos >= 0) begin
                o.slot_index  = hit;
                o.was_present = 1'b1;
                if (tbl_count[hit] == COUNT_MAX) begin
                    o.ref_count = COUNT_MAX;
                    o.status    = ST_SATURATED;
                end else begin
                    tbl_count[hit] = tbl_count[hit] + 1'b1;
                    o.ref_count    = tbl_count[hit];
                    o.status       = ST_OK;
                end
            end else if (live_cnt == ENTRIES) begin
                o.status = ST_FULL;
            end else begin
                // recycled index first, else the next fresh one
                if (free_depth != 0) begin
                    free_depth = free_depth - 1'b1;
                    idx = free_stack[free_depth[IDX_W-1:0]];
                end else begin
                    idx = live_cnt[IDX_W-1:0];
                end
                tbl_valid[idx] = 1'b1;
                tbl_key[idx]   = r.key[KEY_BITS-1:0];
                tbl_count[idx] = CNT_W'(1);
                live_cnt       = live_cnt + 1'b1;
                o.slot_index   = idx;
                o.ref_count    = CNT_W'(1);
                o.status       = ST_OK;
            end
        end else if (pos < 0) begin
            o.status = ST_NOT_FOUND;
        end else begin
            tbl_count[hit] = tbl_count[hit] - 1'b1;
            o.slot_index   = hit;
            o.ref_count    = tbl_count[hit];
            o.was_present  = 1'b1;
            o.status       = ST_OK;
            // last reference gone: index back on the stack
            if (tbl_count[hit] == 0) begin
                tbl_valid[hit]                      = 1'b0;
                free_stack[free_depth[IDX_W-1:0]] = hit;
                free_depth                          = free_depth + 1'b1;
                live_cnt                            = live_cnt - 1'b1;
                o.released                          = 1'b1;
            end
        end
        return o;
    endfunction

    // random key currently in the table, zero if the table is empty
    function automatic logic [KEY_W-1:0] held_key();
        logic [KEY_W-1:0] k;
        int               nth;
        k = '0;
        if (live_cnt == 0) return k;
        nth = $urandom_range(0, live_cnt - 1);
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                if (nth == 0) begin
                    k[KEY_BITS-1:0] = tbl_key[i];
                    return k;
                end
                nth--;
            end
        end
        return k;
    endfunction

    // random key not in the table
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do k = $urandom(); while (find_slot(k) >= 0);
        return k;
    endfunction

    // random keys half the time, else one bit away from a held key or at the extremes
    function automatic logic [KEY_W-1:0] probe_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 7))
            0, 1:    k = held_key() ^ (32'd1 << $urandom_range(0, KEY_W - 1));
            2:       k = $urandom_range(0, 3);
            3:       k = ~32'($urandom_range(0, 3));
            default: k = $urandom();
        endcase
        return k;
    endfunction

    // send one request, idling between bursts unless the sender is steady
    task automatic send_req(input logic act, input logic [KEY_W-1:0] key);
        req_t r;
        int   gap;
        r.action = act;
        r.key    = key;
        if (!tx_steady && burst_left == 0) begin
            gap = $urandom_range(1, 90);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        alloc_rsp_due.push_back(apply_alloc_request(r));
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        mismatches++;
        // keep the log short when something is badly broken
        if (mismatches <= REPORT_LINES) begin
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    // receiver: long hold-off on request, else random stalls
    always @(posedge aclk) begin
        if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 40);
        end
    end

    // response check against the oldest prediction
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (alloc_rsp_due.size() == 0) begin
                report_mismatch("response with no request pending", longint'(m_rsp),
                                longint'(0));
            end else begin
                want = alloc_rsp_due.pop_front();
                if (m_rsp.slot_index !== want.slot_index)
                    report_mismatch("slot_index", longint'(m_rsp.slot_index),
                                    longint'(want.slot_index));
                if (m_rsp.ref_count !== want.ref_count)
                    report_mismatch("ref_count", longint'(m_rsp.ref_count),
                                    longint'(want.ref_count));
                if (m_rsp.was_present !== want.was_present)
                    report_mismatch("was_present", longint'(m_rsp.was_present),
                                    longint'(want.was_present));
                if (m_rsp.released !== want.released)
                    report_mismatch("released", longint'(m_rsp.released),
                                    longint'(want.released));
                if (m_rsp.status !== want.status)
                    report_mismatch("status", longint'(m_rsp.status),
                                    longint'(want.status));
                case (want.status)
                    ST_OK:        n_ok++;
                    ST_NOT_FOUND: n_not_found++;
                    ST_FULL:      n_full++;
                    default:      n_saturated++;
                endcase
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, idle_cycles);
            $display("refcounted_index_allocator verification failed");
            $finish;
        end
    end

    // extreme keys, fresh and recycled indices, unknown keys, empty table
    task automatic test_basic_requests();
        send_req(ACT_ASSIGN,  32'h0000_0000);
        send_req(ACT_ASSIGN,  32'hFFFF_FFFF);
        send_req(ACT_ASSIGN,  32'h0000_0000);
        send_req(ACT_RELEASE, 32'hFFFF_FFFF);
        send_req(ACT_RELEASE, 32'hFFFF_FFFF);
        send_req(ACT_RELEASE, 32'h1234_5678);
        send_req(ACT_ASSIGN,  32'h8000_0000);
        send_req(ACT_ASSIGN,  32'h0000_0001);
        send_req(ACT_RELEASE, 32'h0000_0000);
        send_req(ACT_RELEASE, 32'h0000_0000);
        send_req(ACT_ASSIGN,  32'hFFFF_FFFE);
        send_req(ACT_RELEASE, 32'h0000_0001);
        send_req(ACT_RELEASE, 32'h8000_0000);
        send_req(ACT_RELEASE, 32'hFFFF_FFFE);
        send_req(ACT_RELEASE, 32'h0000_0000);
        send_req(ACT_ASSIGN,  32'hA5A5_A5A5);
    endtask

    // walk one key's count up, back down to zero and past it
    task automatic test_count_walk();
        logic [KEY_W-1:0] k;
        k = fresh_key();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (40) send_req(ACT_ASSIGN, k);
        repeat (40) send_req(ACT_RELEASE, k);
        send_req(ACT_RELEASE, k);
        send_req(ACT_ASSIGN,  k);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // fill the table, try past the end, then free and reuse a few indices
    task automatic test_table_full();
        logic [KEY_W-1:0] added [$];
        logic [KEY_W-1:0] k;
        int               pick;
        while (live_cnt < ENTRIES) begin
            k = fresh_key();
            added.push_back(k);
            send_req(ACT_ASSIGN, k);
        end
        send_req(ACT_ASSIGN,  fresh_key());
        send_req(ACT_ASSIGN,  added[0]);
        send_req(ACT_RELEASE, fresh_key());
        send_req(ACT_RELEASE, added[0]);
        repeat (10) begin
            pick = $urandom_range(0, added.size() - 1);
            send_req(ACT_RELEASE, added[pick]);
            added.delete(pick);
        end
        repeat (10) send_req(ACT_ASSIGN, fresh_key());
        send_req(ACT_ASSIGN, fresh_key());
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_output_backpressure();
        tx_steady = 1'b1;
        hold_ask  = 400;
        repeat (3) send_req(ACT_ASSIGN, held_key());
        send_req(ACT_RELEASE, held_key());
        send_req(ACT_RELEASE, probe_key());
        send_req(ACT_ASSIGN,  probe_key());
        tx_steady = 1'b0;
    endtask

    // phased random mix: filling, draining and balanced stretches
    task automatic test_random_traffic();
        int roll;
        int w_new;
        int w_ref;
        int w_rel;
        w_new = 30;
        w_ref = 25;
        w_rel = 30;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            // new mix and pacing every 150 requests
            if (n % 150 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        w_new = 60; w_ref = 15; w_rel = 15;
                    end
                    1: begin
                        w_new = 10; w_ref = 15; w_rel = 65;
                    end
                    default: begin
                        w_new = 30; w_ref = 25; w_rel = 30;
                    end
                endcase
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll >= 92) begin
                send_req($urandom_range(0, 1) ? ACT_RELEASE : ACT_ASSIGN, $urandom());
            end else if (roll < w_new || live_cnt == 0) begin
                send_req(ACT_ASSIGN, probe_key());
            end else if (roll < w_new + w_ref) begin
                send_req(ACT_ASSIGN, held_key());
            end else if (roll < w_new + w_ref + w_rel) begin
                send_req(ACT_RELEASE, held_key());
            end else begin
                send_req(ACT_RELEASE, probe_key());
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_requests();
        test_count_walk();
        test_table_full();
        test_output_backpressure();
        test_random_traffic();

        // drain, then watch a while for stray responses
        s_valid <= 1'b0;
        rx_steady = 1'b1;
        while (alloc_rsp_due.size() != 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);

        $display("checked %0d responses: %0d ok, %0d unknown key, %0d table full, %0d at ceiling",
                 n_ok + n_not_found + n_full + n_saturated, n_ok, n_not_found, n_full,
                 n_saturated);
        $display("exercised fresh and recycled indices, near-miss keys, bursts, stalls, hold-off");
        if (mismatches == 0) begin
            $display("refcounted_index_allocator verification clean");
        end else begin
            $display("refcounted_index_allocator verification failed");
        end
        $finish;
    end

endmodule

### refcounted_index_allocator.f
hdl/ria_pkg.sv
hdl/ria_table_cell.sv
hdl/ria_stack_cell.sv
hdl/refcounted_index_allocator.sv
bench/tb_top.sv
